/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with reset disable.
`define VRPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define VRPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vrps_pkg.sv */
// Shared constants and codes of the vertex rotate, project and shade block.
`default_nettype none

package vrps_pkg;

	localparam int COORD_FRAC_BITS_DEF = 8;

	localparam int IN_W   = 16;
	localparam int PIX_W  = 12;
	localparam int SIZE_W = 13;
	localparam int BAND_W = 2;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 80;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes
	localparam logic [2:0] REG_COS_X = 3'd0;
	localparam logic [2:0] REG_SIN_X = 3'd1;
	localparam logic [2:0] REG_COS_Y = 3'd2;
	localparam logic [2:0] REG_SIN_Y = 3'd3;
	localparam logic [2:0] REG_COS_Z = 3'd4;
	localparam logic [2:0] REG_SIN_Z = 3'd5;
	localparam logic [2:0] REG_SCR_W = 3'd6;
	localparam logic [2:0] REG_SCR_H = 3'd7;

	localparam logic signed [15:0] TRIG_ONE   = 16'sd16384;
	localparam logic signed [15:0] TRIG_ZERO  = 16'sd0;
	localparam logic [SIZE_W-1:0] SCR_RESET   = 13'd600;
	localparam logic [SIZE_W-1:0] MAX_SCREEN  = 13'd4096;

	// 2000 * 2 for the doubled-denominator form of the projection
	localparam logic signed [12:0] FOCAL2 = 13'sd4000;
	localparam int FOCAL_DIST = 100;

	// shade band codes and thresholds
	localparam logic [BAND_W-1:0] BAND_DARK = 2'd0;
	localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
	localparam logic [BAND_W-1:0] BAND_BASE = 2'd2;
	localparam logic [7:0] BAND_LO = 8'd76;
	localparam logic [7:0] BAND_HI = 8'd130;

	// rotation word widths after each axis
	localparam int ROT1_W = 19;
	localparam int ROT2_W = 22;
	localparam int ROT3_W = 25;

	function automatic logic signed [IN_W-1:0] sat_q88(input logic signed [ROT3_W-1:0] v);
		if (v > 25'sd32767) begin
			return 16'sh7fff;
		end else if (v < -25'sd32768) begin
			return 16'sh8000;
		end
		return v[IN_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/vrps_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module vrps_div #(
	parameter int DEN_W = 18,
	parameter int Q_W   = 12
) (
	input  wire logic                   clk,
	input  wire logic [Q_W-1:0]         ce,
	input  wire logic [DEN_W+Q_W-1:0]   num,
	input  wire logic [DEN_W-1:0]       den,
	output      logic [Q_W-1:0]         quo
);

	logic [DEN_W-1:0] rem_q [Q_W];
	logic [Q_W-1:0]   low_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0]   low_in;
		logic [Q_W-1:0]   quo_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   trial;
		logic             ge;
		logic [DEN_W-1:0] rem_nx;
		logic [Q_W-1:0]   quo_nx;

		if (j == 0) begin : g_first
			assign rem_in = num[DEN_W+Q_W-1:Q_W];
			assign low_in = num[Q_W-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign low_in = low_q[j-1];
			assign quo_in = quo_q[j-1];
			assign den_in = den_q[j-1];
		end

		// shift in the next numerator bit, subtract where it fits
		always_comb begin
			trial  = {rem_in, low_in[Q_W-1-j]};
			ge     = (trial >= {1'b0, den_in});
			rem_nx = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
			quo_nx = quo_in;
			quo_nx[Q_W-1-j] = ge;
		end

		always_ff @(posedge clk) begin
			if (ce[j]) begin
				rem_q[j] <= rem_nx;
				low_q[j] <= low_in;
				quo_q[j] <= quo_nx;
				den_q[j] <= den_in;
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

`default_nettype wire

/* rtl/core/vertex_rotate_project_shade_top.sv */
// Vertex rotate, perspective project and shade, one vertex per clock unless the output stalls.
//
// Input stream (s_t*): one word per vertex: x, y, z in signed fixed point and
// an 8-bit noise level. Output stream (m_t*): one word per vertex with the
// rotated, saturated coordinates, the projected pixel, the shade band, and
// the visible flag in m_tuser.
// Configuration: APB port, eight registers at byte addresses 0, 4, .. 28
// (rotation sine/cosine in Q2.14, screen width and height). Write them only
// while no vertex is in flight.
// Depth: 15 register stages from the capture of s_tdata to m_tvalid; the depth
// is set by the 12 stages of the per-axis divider, one quotient bit each,
// behind three projection stages. Throughput: one vertex per cycle when no
// output stall holds the pipe; m_tvalid is the valid bit of the last stage.
// Each stage loads when it is empty or its successor loads, so bubbles
// collapse and s_tready stays high while the output waits as long as a
// stage is free. A stall at the output holds the words; nothing is lost.
// Reset: valid bits clear, registers go to identity rotation and 600x600.
`default_nettype none

module vertex_rotate_project_shade_top import vrps_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// in_x [15:0], in_y [31:16], in_z [47:32], noise_level [55:48]
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	// rot_x [15:0], rot_y [31:16], rot_z [47:32], pixel_x [59:48],
	// pixel_y [71:60], shade_band [73:72], zero [79:74]
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [M_TDATA_W-1:0]   m_tdata,
	// visible [0]
	output      logic [0:0]             m_tuser,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output      logic [APB_DATA_W-1:0]  prdata,
	output      logic                   pready
);

	// depth term d = z + 100 * 2^F, its double is the divisor
	localparam int D_W     = $clog2(32768 + FOCAL_DIST * (2 ** COORD_FRAC_BITS));
	localparam int DEN_W   = D_W + 1;
	localparam int SD_W    = D_W + SIZE_W;
	localparam int NUM_W   = ((SD_W > 27) ? SD_W : 27) + 2;
	localparam int NUM_U_W = DEN_W + PIX_W;
	localparam int NST     = 15;
	localparam int DIV_S   = 4;
	localparam int DLY_S   = 8;
	localparam logic [D_W-1:0] Z_OFFSET = D_W'(FOCAL_DIST * (2 ** COORD_FRAC_BITS));

	typedef struct packed {
		logic signed [IN_W-1:0] rx;
		logic signed [IN_W-1:0] ry;
		logic signed [IN_W-1:0] rz;
		logic [BAND_W-1:0]      band;
		logic                   vis;
	} res_t;

	// ---------------- configuration registers ----------------
	logic signed [15:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
	logic [SIZE_W-1:0]  scr_w_q, scr_h_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= TRIG_ONE;
			sin_x_q <= TRIG_ZERO;
			cos_y_q <= TRIG_ONE;
			sin_y_q <= TRIG_ZERO;
			cos_z_q <= TRIG_ONE;
			sin_z_q <= TRIG_ZERO;
			scr_w_q <= SCR_RESET;
			scr_h_q <= SCR_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_COS_X: cos_x_q <= pwdata[15:0];
				REG_SIN_X: sin_x_q <= pwdata[15:0];
				REG_COS_Y: cos_y_q <= pwdata[15:0];
				REG_SIN_Y: sin_y_q <= pwdata[15:0];
				REG_COS_Z: cos_z_q <= pwdata[15:0];
				REG_SIN_Z: sin_z_q <= pwdata[15:0];
				REG_SCR_W: scr_w_q <= pwdata[SIZE_W-1:0];
				REG_SCR_H: scr_h_q <= pwdata[SIZE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_COS_X: prdata = {16'd0, cos_x_q};
			REG_SIN_X: prdata = {16'd0, sin_x_q};
			REG_COS_Y: prdata = {16'd0, cos_y_q};
			REG_SIN_Y: prdata = {16'd0, sin_y_q};
			REG_COS_Z: prdata = {16'd0, cos_z_q};
			REG_SIN_Z: prdata = {16'd0, sin_z_q};
			REG_SCR_W: prdata = {19'd0, scr_w_q};
			REG_SCR_H: prdata = {19'd0, scr_h_q};
			default:   prdata = '0;
		endcase
	end

	// clamp oversized screens to the largest supported size
	logic [SIZE_W-1:0] w_sz, h_sz;
	assign w_sz = (scr_w_q > MAX_SCREEN) ? MAX_SCREEN : scr_w_q;
	assign h_sz = (scr_h_q > MAX_SCREEN) ? MAX_SCREEN : scr_h_q;

	// ---------------- pipeline control ----------------
	// A stage loads when empty or when the stage after it loads.
	logic [NST:1] vld_q;
	logic [NST:1] ce;

	always_comb begin
		ce[NST] = !vld_q[NST] || m_tready;
		for (int k = NST - 1; k >= 1; k--) begin
			ce[k] = !vld_q[k] || ce[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ce[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (ce[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = ce[1];

	// ---------------- stage 1: capture, depth term, band ----------------
	logic signed [IN_W-1:0] x_s1, y_s1, z_s1;
	logic [D_W-1:0]         d_s1;
	logic                   front_s1;
	logic [BAND_W-1:0]      band_s1;
	logic [7:0]             noise_in;

	assign noise_in = s_tdata[55:48];

	always_ff @(posedge clk) begin
		if (ce[1]) begin
			x_s1     <= s_tdata[15:0];
			y_s1     <= s_tdata[31:16];
			z_s1     <= s_tdata[47:32];
			d_s1     <= D_W'(s_tdata[46:32]) + Z_OFFSET;
			front_s1 <= !s_tdata[47];
			band_s1  <= (noise_in <= BAND_LO) ? BAND_DARK :
			            ((noise_in <= BAND_HI) ? BAND_MID : BAND_BASE);
		end
	end

	// ---------------- stage 2: products ----------------
	logic signed [27:0]     pcx_s2, pcy_s2;
	logic [SD_W-1:0]        sdx_s2, sdy_s2;
	logic signed [31:0]     yc_s2, zs_s2, ys_s2, zc_s2;
	logic signed [IN_W-1:0] x_s2;
	logic [D_W-1:0]         d_s2;
	logic                   front_s2;
	logic [BAND_W-1:0]      band_s2;

	always_ff @(posedge clk) begin
		if (ce[2]) begin
			pcx_s2   <= 28'(x_s1) * 28'(FOCAL2);
			pcy_s2   <= 28'(y_s1) * 28'(FOCAL2);
			sdx_s2   <= SD_W'(w_sz) * SD_W'(d_s1);
			sdy_s2   <= SD_W'(h_sz) * SD_W'(d_s1);
			yc_s2    <= 32'(y_s1) * 32'(cos_x_q);
			zs_s2    <= 32'(z_s1) * 32'(sin_x_q);
			ys_s2    <= 32'(y_s1) * 32'(sin_x_q);
			zc_s2    <= 32'(z_s1) * 32'(cos_x_q);
			x_s2     <= x_s1;
			d_s2     <= d_s1;
			front_s2 <= front_s1;
			band_s2  <= band_s1;
		end
	end

	// ---------------- stage 3: clip test, X rotation ----------------
	logic signed [NUM_W-1:0] numx, numy, limx, limy;
	logic                    vis_nx;
	logic signed [32:0]      y1_sum, z1_sum;

	always_comb begin
		numx   = NUM_W'(pcx_s2) + $signed(NUM_W'(sdx_s2));
		numy   = NUM_W'(pcy_s2) + $signed(NUM_W'(sdy_s2));
		limx   = $signed(NUM_W'(sdx_s2) << 1);
		limy   = $signed(NUM_W'(sdy_s2) << 1);
		vis_nx = front_s2 && !numx[NUM_W-1] && (numx < limx)
		                  && !numy[NUM_W-1] && (numy < limy);
		y1_sum = 33'(yc_s2) - 33'(zs_s2) + 33'sd8192;
		z1_sum = 33'(ys_s2) + 33'(zc_s2) + 33'sd8192;
	end

	logic [NUM_U_W-1:0]       nx_s3, ny_s3;
	logic [DEN_W-1:0]         den_s3;
	logic                     vis_s3;
	logic [BAND_W-1:0]        band_s3;
	logic signed [IN_W-1:0]   x_s3;
	logic signed [ROT1_W-1:0] y1_s3, z1_s3;

	always_ff @(posedge clk) begin
		if (ce[3]) begin
			// feed zero for hidden vertices so the divider stays in range
			nx_s3   <= vis_nx ? numx[NUM_U_W-1:0] : '0;
			ny_s3   <= vis_nx ? numy[NUM_U_W-1:0] : '0;
			den_s3  <= {d_s2, 1'b0};
			vis_s3  <= vis_nx;
			band_s3 <= band_s2;
			x_s3    <= x_s2;
			y1_s3   <= y1_sum[32:14];
			z1_s3   <= z1_sum[32:14];
		end
	end

	// ---------------- stages 4..15: pixel dividers ----------------
	logic [PIX_W-1:0] pix_x, pix_y;

	vrps_div #(
		.DEN_W (DEN_W),
		.Q_W   (PIX_W)
	) u_div_x (
		.clk  (clk),
		.ce   (ce[DIV_S +: PIX_W]),
		.num  (nx_s3),
		.den  (den_s3),
		.quo  (pix_x)
	);

	vrps_div #(
		.DEN_W (DEN_W),
		.Q_W   (PIX_W)
	) u_div_y (
		.clk  (clk),
		.ce   (ce[DIV_S +: PIX_W]),
		.num  (ny_s3),
		.den  (den_s3),
		.quo  (pix_y)
	);

	// ---------------- stage 4: Y rotation products ----------------
	logic signed [35:0]       xcy_s4, zsy_s4, zcy_s4, xsy_s4;
	logic signed [ROT1_W-1:0] y1_s4;
	logic                     vis_s4;
	logic [BAND_W-1:0]        band_s4;

	always_ff @(posedge clk) begin
		if (ce[4]) begin
			xcy_s4  <= 36'(x_s3) * 36'(cos_y_q);
			zsy_s4  <= 36'(z1_s3) * 36'(sin_y_q);
			zcy_s4  <= 36'(z1_s3) * 36'(cos_y_q);
			xsy_s4  <= 36'(x_s3) * 36'(sin_y_q);
			y1_s4   <= y1_s3;
			vis_s4  <= vis_s3;
			band_s4 <= band_s3;
		end
	end

	// ---------------- stage 5: Y rotation round ----------------
	logic signed [35:0]       x2_sum, z2_sum;
	logic signed [ROT2_W-1:0] x2_s5, z2_s5;
	logic signed [ROT1_W-1:0] y1_s5;
	logic                     vis_s5;
	logic [BAND_W-1:0]        band_s5;

	assign x2_sum = xcy_s4 + zsy_s4 + 36'sd8192;
	assign z2_sum = zcy_s4 - xsy_s4 + 36'sd8192;

	always_ff @(posedge clk) begin
		if (ce[5]) begin
			x2_s5   <= x2_sum[35:14];
			z2_s5   <= z2_sum[35:14];
			y1_s5   <= y1_s4;
			vis_s5  <= vis_s4;
			band_s5 <= band_s4;
		end
	end

	// ---------------- stage 6: Z rotation products ----------------
	logic signed [38:0]       xcz_s6, ysz_s6, xsz_s6, ycz_s6;
	logic signed [ROT2_W-1:0] z2_s6;
	logic                     vis_s6;
	logic [BAND_W-1:0]        band_s6;

	always_ff @(posedge clk) begin
		if (ce[6]) begin
			xcz_s6  <= 39'(x2_s5) * 39'(cos_z_q);
			ysz_s6  <= 39'(y1_s5) * 39'(sin_z_q);
			xsz_s6  <= 39'(x2_s5) * 39'(sin_z_q);
			ycz_s6  <= 39'(y1_s5) * 39'(cos_z_q);
			z2_s6   <= z2_s5;
			vis_s6  <= vis_s5;
			band_s6 <= band_s5;
		end
	end

	// ---------------- stage 7: Z rotation round, saturate ----------------
	logic signed [38:0] x3_sum, y3_sum;
	res_t               res_s7;

	assign x3_sum = xcz_s6 - ysz_s6 + 39'sd8192;
	assign y3_sum = xsz_s6 + ycz_s6 + 39'sd8192;

	always_ff @(posedge clk) begin
		if (ce[7]) begin
			res_s7.rx   <= sat_q88(x3_sum[38:14]);
			res_s7.ry   <= sat_q88(y3_sum[38:14]);
			res_s7.rz   <= sat_q88(ROT3_W'(z2_s6));
			res_s7.vis  <= vis_s6;
			res_s7.band <= band_s6;
		end
	end

	// ---------------- stages 8..15: align with the dividers ----------------
	res_t res_q [NST:DLY_S];

	for (genvar k = DLY_S; k <= NST; k++) begin : g_dly
		if (k == DLY_S) begin : g_head
			always_ff @(posedge clk) begin
				if (ce[k]) begin
					res_q[k] <= res_s7;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (ce[k]) begin
					res_q[k] <= res_q[k-1];
				end
			end
		end
	end

	// ---------------- output ----------------
	res_t res_o;
	assign res_o    = res_q[NST];
	assign m_tvalid = vld_q[NST];
	assign m_tuser  = res_o.vis;
	assign m_tdata  = {6'd0, res_o.band,
	                   res_o.vis ? pix_y : {PIX_W{1'b0}},
	                   res_o.vis ? pix_x : {PIX_W{1'b0}},
	                   res_o.rz, res_o.ry, res_o.rx};

endmodule

`default_nettype wire

/* rtl/core/vrps_checker.sv */
// Port-level checker for the vertex rotate, project and shade block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module vrps_checker import vrps_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [0:0]           m_tuser
);

	// hold a stalled output word
	`VRPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// hidden vertices carry a zero pixel
	`VRPS_ASSERT(a_hidden_zero, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata[71:48] == 24'd0), "hidden vertex with nonzero pixel")

	// band is one of the three codes
	`VRPS_ASSERT(a_band_code, clk, arst_n, m_tvalid |-> (m_tdata[73:72] == BAND_DARK || m_tdata[73:72] == BAND_MID || m_tdata[73:72] == BAND_BASE), "illegal shade band")

	// padding bits stay clear
	`VRPS_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> (m_tdata[79:74] == 6'd0), "padding bits set")

endmodule

bind vertex_rotate_project_shade_top vrps_checker u_vrps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench of the vertex rotate, project and shade block.
`default_nettype none

module testbench;
	import vrps_pkg::*;

	localparam int LATENCY     = 15;
	localparam int N_RANDOM    = 1350;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [BAND_W-1:0]        band;
		logic [PIX_W-1:0]         pix_y;
		logic [PIX_W-1:0]         pix_x;
		logic signed [IN_W-1:0]   rz;
		logic signed [IN_W-1:0]   ry;
		logic signed [IN_W-1:0]   rx;
		logic                     vis;
	} vertex_out_t;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic [7:0]         noise;
		bit                 typed;
		vertex_out_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// shadow copy of the configuration registers
	logic [15:0] trig_reg [6];
	logic [12:0] scr_w, scr_h;

	vertex_out_t expected_words[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  calm = 1'b0;     // last part of the run: no idling
	bit  sink_run = 1'b0;

	vertex_rotate_project_shade_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Round to nearest, ties up, of v / 2^14.
	function automatic longint round14(longint v);
		longint t;
		t = v + 8192;
		return t >>> 14;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Project one axis; returns -1 when the pixel falls off the screen.
	function automatic longint project(longint c, longint d, longint size);
		longint num;
		num = 4000 * c + size * d;
		if (num < 0 || num >= 2 * size * d) return -1;
		return num / (2 * d);
	endfunction

	function automatic vertex_out_t transform_vertex(logic signed [15:0] xi,
			logic signed [15:0] yi, logic signed [15:0] zi, logic [7:0] noise);
		vertex_out_t r;
		longint x, y, z, a, b, d, w, h, tx, ty;
		longint cx, sx, cy, sy, cz, sz;
		x = xi; y = yi; z = zi;
		cx = $signed(trig_reg[REG_COS_X]); sx = $signed(trig_reg[REG_SIN_X]);
		cy = $signed(trig_reg[REG_COS_Y]); sy = $signed(trig_reg[REG_SIN_Y]);
		cz = $signed(trig_reg[REG_COS_Z]); sz = $signed(trig_reg[REG_SIN_Z]);
		w = (scr_w > 4096) ? 4096 : scr_w;
		h = (scr_h > 4096) ? 4096 : scr_h;
		r = '0;
		if (z >= 0) begin
			d = z + 100 * (1 << COORD_FRAC_BITS_DEF);
			tx = project(x, d, w);
			ty = project(y, d, h);
			if (tx >= 0 && ty >= 0) begin
				r.vis = 1'b1;
				r.pix_x = tx[PIX_W-1:0];
				r.pix_y = ty[PIX_W-1:0];
			end
		end
		r.band = (noise <= BAND_LO) ? BAND_DARK : (noise <= BAND_HI) ? BAND_MID : BAND_BASE;
		a = round14(y * cx - z * sx);
		b = round14(y * sx + z * cx);
		y = a; z = b;
		a = round14(x * cy + z * sy);
		b = round14(z * cy - x * sy);
		x = a; z = b;
		a = round14(x * cz - y * sz);
		b = round14(x * sz + y * cz);
		x = a; y = b;
		r.rx = 16'(clamp16(x));
		r.ry = 16'(clamp16(y));
		r.rz = 16'(clamp16(z));
		return r;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_SCR_W) scr_w = val[12:0];
		else if (idx == REG_SCR_H) scr_h = val[12:0];
		else trig_reg[idx] = val[15:0];
	endtask

	// Hold until every word is back, then let the pipe drain fully.
	task automatic drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [7:0] noise);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {noise, z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_words = {expected_words, transform_vertex(x, y, z, noise)};
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
	endtask

	// Pick a coordinate: moderate half the time, else full-range random or extreme.
	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($urandom);
			default: return $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
		endcase
	endfunction

	function automatic logic [15:0] rand_trig();
		case ($urandom_range(0, 5))
			0: return 16'h4000;
			1: return 16'hc000;
			2: return 16'h0000;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Drop m_tready in random bursts; hold it steady when calm.
	always @(posedge clk) begin
		int stall;
		if (sink_run) begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare every accepted output word with the oldest expectation.
	always @(posedge clk) begin
		vertex_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.rx = m_tdata[15:0];
			got.ry = m_tdata[31:16];
			got.rz = m_tdata[47:32];
			got.pix_x = m_tdata[59:48];
			got.pix_y = m_tdata[71:60];
			got.band = m_tdata[73:72];
			got.vis = m_tuser[0];
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (got.rx !== want.rx)
					$display("%0t: rot_x expected %0d actual %0d", $time, want.rx, got.rx);
				if (got.ry !== want.ry)
					$display("%0t: rot_y expected %0d actual %0d", $time, want.ry, got.ry);
				if (got.rz !== want.rz)
					$display("%0t: rot_z expected %0d actual %0d", $time, want.rz, got.rz);
				if (got.pix_x !== want.pix_x)
					$display("%0t: pixel_x expected %0d actual %0d", $time, want.pix_x,
						got.pix_x);
				if (got.pix_y !== want.pix_y)
					$display("%0t: pixel_y expected %0d actual %0d", $time, want.pix_y,
						got.pix_y);
				if (got.band !== want.band)
					$display("%0t: shade_band expected %0d actual %0d", $time, want.band,
						got.band);
				if (got.vis !== want.vis)
					$display("%0t: visible expected %0d actual %0d", $time, want.vis, got.vis);
				if (got !== want) mismatches++;
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Directed table: identity rotation, 600x600 screen after reset.
	stim_row_t table_rows[$];

	function automatic stim_row_t row(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [7:0] n, bit typed, vertex_out_t want);
		stim_row_t r;
		r.x = x; r.y = y; r.z = z; r.noise = n; r.typed = typed; r.want = want;
		return r;
	endfunction

	initial begin
		vertex_out_t w;
		int phase, k;
		logic [15:0] v;
		for (k = 0; k < 6; k++) trig_reg[k] = (k % 2 == 0) ? TRIG_ONE : TRIG_ZERO;
		scr_w = SCR_RESET; scr_h = SCR_RESET;
		// origin: centered pixel, darkest band
		w = '0; w.vis = 1'b1; w.pix_x = 12'd300; w.pix_y = 12'd300; w.band = BAND_DARK;
		table_rows = {table_rows, row(0, 0, 0, 8'd0, 1'b1, w)};
		// negative depth culls, band boundaries
		w = '0; w.rz = -16'sd1; w.band = BAND_DARK;
		table_rows = {table_rows, row(0, 0, -16'sd1, 8'd76, 1'b1, w)};
		w = '0; w.rz = -16'sd1; w.band = BAND_MID;
		table_rows = {table_rows, row(0, 0, -16'sd1, 8'd77, 1'b1, w)};
		w = '0; w.rz = -16'sd1; w.band = BAND_MID;
		table_rows = {table_rows, row(0, 0, -16'sd1, 8'd130, 1'b1, w)};
		w = '0; w.rz = -16'sd1; w.band = BAND_BASE;
		table_rows = {table_rows, row(0, 0, -16'sd1, 8'd131, 1'b1, w)};
		w = '0; w.rx = 16'sh7fff; w.ry = 16'sh8000; w.rz = 16'sh8000; w.band = BAND_BASE;
		table_rows = {table_rows, row(16'sh7fff, 16'sh8000, 16'sh8000, 8'd255, 1'b1, w)};
		table_rows = {table_rows, row(16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd255, 1'b0, w)};
		table_rows = {table_rows, row(16'sh8000, 16'sh8000, 16'sh7fff, 8'd1, 1'b0, w)};
		table_rows = {table_rows, row(16'sh8000, 16'sh8000, 0, 8'd128, 1'b0, w)};
		table_rows = {table_rows, row(16'sd7680, -16'sd7680, 0, 8'd200, 1'b0, w)};
		table_rows = {table_rows, row(16'sd7679, -16'sd7679, 0, 8'd100, 1'b0, w)};
		table_rows = {table_rows, row(-16'sd7681, 16'sd7681, 16'sd256, 8'd50, 1'b0, w)};
		table_rows = {table_rows, row(16'h5555, 16'haaaa, 16'h5555, 8'haa, 1'b0, w)};
		table_rows = {table_rows, row(16'haaaa, 16'h5555, 16'h2aaa, 8'h55, 1'b0, w)};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_run = 1'b1;

		foreach (table_rows[i]) begin
			send_vertex(table_rows[i].x, table_rows[i].y, table_rows[i].z,
				table_rows[i].noise);
			// replace the predicted word with the typed one where given
			if (table_rows[i].typed) expected_words[$] = table_rows[i].want;
		end
		end_burst();
		drain();

		// Extremes of screen size and rotation, then random settings.
		for (phase = 0; phase < 9; phase++) begin
			for (k = 0; k < 6; k++) begin
				case (phase)
					0: v = (k % 2 == 0) ? 16'hc000 : 16'h0000;
					1: v = (k % 2 == 0) ? 16'h0000 : 16'h4000;
					2: v = (k % 2 == 0) ? 16'h0000 : 16'hc000;
					3: v = 16'h4000;
					4: v = 16'hc000;
					default: v = rand_trig();
				endcase
				reg_write(k[2:0], {16'h0, v});
			end
			case (phase)
				0: begin reg_write(REG_SCR_W, 32'd1); reg_write(REG_SCR_H, 32'd1); end
				1: begin reg_write(REG_SCR_W, 32'd4096); reg_write(REG_SCR_H, 32'd4096); end
				2: begin reg_write(REG_SCR_W, 32'h1fff); reg_write(REG_SCR_H, 32'd0); end
				3: begin reg_write(REG_SCR_W, 32'd0); reg_write(REG_SCR_H, 32'd4097); end
				default: begin
					reg_write(REG_SCR_W, $urandom_range(1, 4096));
					reg_write(REG_SCR_H, $urandom_range(1, 4096));
				end
			endcase
			if (phase == 8) calm = 1'b1;
			repeat (N_RANDOM / 9) begin
				send_vertex(rand_coord(), rand_coord(),
					($urandom_range(0, 3) == 0) ? rand_coord()
						: 16'($urandom_range(0, 20000)), 8'($urandom));
				// sender hold-off until all words are back
				if (!calm && $urandom_range(0, 200) == 0) begin
					end_burst();
					while (expected_words.size() != 0) @(posedge clk);
				end
			end
			end_burst();
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
